[hw/rtl/cc20_pkg.sv]
// shared types, constants and round functions for the chacha20 keystream xor block
package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned ROUNDS        = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RND_W         = $clog2(ROUNDS);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR    = 3'd6;

  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    logic [31:0] in_word;
    logic [2:0]  valid_bytes;
    logic        message_start;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  out_valid_bytes;
  } out_item_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
    logic [31:0]      init_ctr;
  } cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nvalid;
    logic        new_pad;
    logic [31:0] counter;
    logic [3:0]  index;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              full;
    logic              nonempty;
  } q_stat_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic qr_t cc_quarter(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] c, input logic [31:0] d);
    logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2, t;
    qr_t r;
    a1 = a + b;
    t  = d ^ a1;
    d1 = {t[15:0], t[31:16]};
    c1 = c + d1;
    t  = b ^ c1;
    b1 = {t[19:0], t[31:20]};
    a2 = a1 + b1;
    t  = d1 ^ a2;
    d2 = {t[23:0], t[31:24]};
    c2 = c1 + d2;
    t  = b1 ^ c2;
    b2 = {t[24:0], t[31:25]};
    r.a = a2;
    r.b = b2;
    r.c = c2;
    r.d = d2;
    return r;
  endfunction

  // column round when diag is low, diagonal round when high
  function automatic state_t cc_round(input state_t s, input logic diag);
    state_t     o;
    qr_t        q;
    logic [1:0] lane, sb, sc, sd;
    o = s;
    for (int i = 0; i < 4; i++) begin
      lane = 2'(i);
      sb   = lane + (diag ? 2'd1 : 2'd0);
      sc   = lane + (diag ? 2'd2 : 2'd0);
      sd   = lane + (diag ? 2'd3 : 2'd0);
      q = cc_quarter(s[{2'b00, lane}], s[{2'b01, sb}], s[{2'b10, sc}], s[{2'b11, sd}]);
      o[{2'b00, lane}] = q.a;
      o[{2'b01, sb}]   = q.b;
      o[{2'b10, sc}]   = q.c;
      o[{2'b11, sd}]   = q.d;
    end
    return o;
  endfunction

  function automatic state_t cc_init(input cfg_t cfg, input logic [31:0] counter);
    state_t s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      s[4 + i] = cfg.key[i];
    end
    s[12] = counter;
    s[13] = cfg.nonce[0];
    s[14] = cfg.nonce[1];
    s[15] = cfg.nonce[2];
    return s;
  endfunction

  function automatic logic [31:0] cc_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/cc20_front.sv]
// front end: accepts words, tracks block counter and word index, queues jobs
module cc20_front import cc20_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  input  logic [31:0] init_ctr_i,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output job_t        push_job_o
);

  logic [31:0] ctr_q, ctr_d, ctr_eff;
  logic [3:0]  idx_q, idx_d, idx_eff;
  logic        new_pad;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    ctr_eff = in_item_i.message_start ? init_ctr_i : ctr_q;
    idx_eff = in_item_i.message_start ? 4'd0 : idx_q;
    new_pad = (idx_eff == 4'd0);

    push_job_o.word    = in_item_i.in_word;
    push_job_o.nvalid  = in_item_i.valid_bytes;
    push_job_o.new_pad = new_pad;
    push_job_o.counter = ctr_eff;
    push_job_o.index   = idx_eff;

    ctr_d = ctr_q;
    idx_d = idx_q;
    if (push_o) begin
      ctr_d = new_pad ? ctr_eff + 32'd1 : ctr_eff;
      idx_d = idx_eff + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      idx_q <= '0;
    end else begin
      ctr_q <= ctr_d;
      idx_q <= idx_d;
    end
  end

endmodule

[hw/rtl/cc20_queue.sv]
// short job queue between front end and keystream engine
module cc20_queue import cc20_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    push_job_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.level    = cnt_q;
  assign stat_o.full     = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.nonempty = (cnt_q != '0);
  assign head_o          = mem_q[rd_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.nonempty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/cc20_engine.sv]
// back end: round unit, pad store and output register
module cc20_engine import cc20_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_stat_t   q_stat_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FEED  = 2'd2;
  localparam logic [1:0] ST_XOR   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  state_t           work_q, work_d;
  state_t           pad_q, pad_d;
  job_t             job_q, job_d;
  state_t           init_s;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             out_free, out_load;
  job_t             src;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign init_s      = cc_init(cfg_i, job_q.counter);

  always_comb begin
    state_d  = state_q;
    rnd_d    = rnd_q;
    work_d   = work_q;
    pad_d    = pad_q;
    job_d    = job_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    src      = head_i;
    case (state_q)
      ST_IDLE: begin
        if (q_stat_i.nonempty) begin
          if (head_i.new_pad) begin
            pop_o   = 1'b1;
            job_d   = head_i;
            work_d  = cc_init(cfg_i, head_i.counter);
            rnd_d   = '0;
            state_d = ST_ROUND;
          end else if (out_free) begin
            pop_o    = 1'b1;
            out_load = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        work_d = cc_round(work_q, rnd_q[0]);
        rnd_d  = rnd_q + RND_W'(1);
        if (rnd_q == RND_W'(ROUNDS - 1)) begin
          state_d = ST_FEED;
        end
      end
      ST_FEED: begin
        for (int i = 0; i < 16; i++) begin
          pad_d[i] = init_s[i] + work_q[i];
        end
        state_d = ST_XOR;
      end
      ST_XOR: begin
        src = job_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_d.out_word        = (src.word ^ pad_q[src.index]) & cc_mask(src.nvalid);
    out_d.out_valid_bytes = src.nvalid;

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    pad_q  <= pad_d;
    job_q  <= job_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/chacha20_keystream_xor.sv]
// top level of the chacha20 keystream xor block with configuration registers
// Encrypts or decrypts a stream of 32-bit little-endian words with the ChaCha20
// keystream (IETF layout: 256-bit key, 32-bit block counter, 96-bit nonce).
// Load key, nonce and initial counter through the write port while the block is
// idle, then flag the first word of each message with message_start. A word
// that opens a new 64-byte pad is queued, then the round unit computes one
// column or diagonal round per cycle; the start state is then added and the
// word is xored with the new pad into the output register. The other 15
// words of a pad are xored with the stored pad without new rounds. A
// two-entry job queue lets input be accepted while the round unit works,
// and the output register holds a result while the sink stalls.
// Bytes beyond valid_bytes in the result are zero.
module chacha20_keystream_xor import cc20_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  cfg_t    cfg_q, cfg_d;
  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_PART0:  cfg_d.key[1:0] = cfg_wdata_i;
        CFG_KEY_PART1:  cfg_d.key[3:2] = cfg_wdata_i;
        CFG_KEY_PART2:  cfg_d.key[5:4] = cfg_wdata_i;
        CFG_KEY_PART3:  cfg_d.key[7:6] = cfg_wdata_i;
        CFG_NONCE_LOW:  cfg_d.nonce[1:0] = cfg_wdata_i;
        CFG_NONCE_HIGH: cfg_d.nonce[2] = cfg_wdata_i[31:0];
        CFG_INIT_CTR:   cfg_d.init_ctr = cfg_wdata_i[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cc20_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .init_ctr_i (cfg_q.init_ctr),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_job_o (push_job)
  );

  cc20_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  cc20_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.level <= QCNT_W'(QDEPTH))
    else $error("job queue level out of range");

  // queue level moves by at most one entry per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.level == $past(q_stat.level)) ||
    (q_stat.level == $past(q_stat.level) + QCNT_W'(1)) ||
    (q_stat.level == $past(q_stat.level) - QCNT_W'(1)))
    else $error("job queue level jumped");

  // bytes beyond the valid count are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.out_word & ~cc_mask(out_item_o.out_valid_bytes)) == '0))
    else $error("invalid output bytes not cleared");

  // the engine only takes a job that is present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_stat.nonempty)
    else $error("job popped from empty queue");

endmodule
